>>> design/cppi_pkg.sv
package cppi_pkg;

  localparam int MAX_NODES   = 16;
  localparam int NODE_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int COORD_W     = 16;
  localparam int SPEED_W     = 16;
  localparam int TIME_W      = 32;
  localparam int NODE_WORD_W = 2 * COORD_W + SPEED_W;

  // Datapath widths of the bit-serial units
  localparam int ACC_W   = 56;
  localparam int DV_W    = 56;
  localparam int REM_W   = 33;
  localparam int ROOT_W  = 28;
  localparam int MS_W    = 28;
  localparam int OPB_W   = 20;
  localparam int CNT_W   = 6;
  localparam int MAG_W   = COORD_W + 1;

  // Step counts of each serial operation
  localparam int SQ_STEPS   = MAG_W;
  localparam int SCALE_BITS = 20;
  localparam int SQRT_STEPS = DV_W / 2;
  localparam int SEG_K      = ROOT_W;
  localparam int LERP_K     = 44;
  localparam int MOD_K      = TIME_W;

  localparam logic [OPB_W-1:0] SCALE = OPB_W'(1000000);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2,
    OP_SETPOS  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                       operation;
    logic [NODE_W-1:0]         node_index;
    logic signed [COORD_W-1:0] node_x;
    logic signed [COORD_W-1:0] node_y;
    logic [SPEED_W-1:0]        node_speed;
    logic [TIME_W-1:0]         tick_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [NODE_W-1:0]         segment_node;
    logic                      timing_started;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SPEED_W-1:0]        speed;
  } node_t;

endpackage

>>> design/closed_path_position_interpolator_unit.sv
// Node write, set position and a tick with timing not yet started go straight to S_OUT,
// where the result is registered once the output register is free; a restart first reads
// node 0 (S_RS_RD, S_RS_LD). Other ticks walk the segments: read the nodes, square the
// distance, scale, take the square root and divide by the speed (skipped at zero speed),
// reduce whole laps once, then interpolate each axis with the bit-serial multiplier and
// divider. Throughput: one item at a time, the next taken once the result is registered.
// Reset (rst, synchronous): position, nodes, timing cleared, node count 1; node table kept.
module closed_path_position_interpolator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cppi_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cppi_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [cppi_pkg::COUNT_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_RS_RD, S_RS_LD, S_RD_CUR, S_RD_NXT, S_LD_NXT, S_MDX, S_MDY, S_MK,
    S_SQRT, S_DIVT, S_CHK, S_MOD, S_MODF, S_TEST, S_LA, S_LB, S_LDIV, S_OUT
  } state_t;

  state_t state;

  // Architectural state
  logic [cppi_pkg::COUNT_W-1:0]        node_count;
  logic [cppi_pkg::NODE_W-1:0]         cur_node;
  logic [cppi_pkg::NODE_W-1:0]         nxt_node;
  logic [cppi_pkg::TIME_W-1:0]         seg_start;
  logic signed [cppi_pkg::COORD_W-1:0] seg_sx;
  logic signed [cppi_pkg::COORD_W-1:0] seg_sy;
  logic signed [cppi_pkg::COORD_W-1:0] cur_x;
  logic signed [cppi_pkg::COORD_W-1:0] cur_y;
  logic                                started;

  // Walk state
  logic [cppi_pkg::TIME_W-1:0]         elapsed;
  logic [cppi_pkg::TIME_W-1:0]         lap;
  logic [cppi_pkg::COUNT_W-1:0]        n;
  logic                                lap_done;
  logic                                stepping;
  logic [cppi_pkg::MS_W-1:0]           ms;
  logic signed [cppi_pkg::COORD_W-1:0] nx;
  logic signed [cppi_pkg::COORD_W-1:0] ny;
  logic [cppi_pkg::SPEED_W-1:0]        spd;
  logic                                axis;
  logic                                qneg;

  // Serial arithmetic registers
  logic [cppi_pkg::ACC_W-1:0]          acc;
  logic [cppi_pkg::ACC_W-1:0]          opa;
  logic [cppi_pkg::OPB_W-1:0]          opb;
  logic                                mneg;
  logic [cppi_pkg::DV_W-1:0]           dv;
  logic [cppi_pkg::REM_W-1:0]          rem;
  logic [cppi_pkg::TIME_W-1:0]         den;
  logic [cppi_pkg::ROOT_W-1:0]         root;
  logic [cppi_pkg::CNT_W-1:0]          cnt;

  // Node memory
  logic                                ram_we;
  logic [cppi_pkg::NODE_W-1:0]         raddr;
  logic [cppi_pkg::NODE_WORD_W-1:0]    rdata;
  cppi_pkg::node_t                     wr_node;
  cppi_pkg::node_t                     rd_node;

  logic                                in_xfer;
  logic                                last;
  logic [cppi_pkg::COUNT_W-1:0]        count_eff;

  function automatic logic [cppi_pkg::NODE_W-1:0] succ(
    input logic [cppi_pkg::NODE_W-1:0]  i,
    input logic [cppi_pkg::COUNT_W-1:0] c
  );
    return ({1'b0, i} >= c - cppi_pkg::COUNT_W'(1)) ? '0 : i + cppi_pkg::NODE_W'(1);
  endfunction

  function automatic logic [cppi_pkg::MAG_W-1:0] mag17(
    input logic signed [cppi_pkg::MAG_W-1:0] v
  );
    return v[cppi_pkg::MAG_W-1] ? -v : v;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign last     = (cnt == cppi_pkg::CNT_W'(1));

  // Clamp the node count into one..MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      count_eff = cppi_pkg::COUNT_W'(1);
    end else if (node_count > cppi_pkg::COUNT_W'(cppi_pkg::MAX_NODES)) begin
      count_eff = cppi_pkg::COUNT_W'(cppi_pkg::MAX_NODES);
    end else begin
      count_eff = node_count;
    end
  end

  assign ram_we  = in_xfer && (in_data.operation == cppi_pkg::OP_WRITE);
  assign wr_node = '{x: in_data.node_x, y: in_data.node_y, speed: in_data.node_speed};
  assign raddr   = (state == S_RD_CUR || state == S_RS_RD) ? cur_node : nxt_node;
  assign rd_node = cppi_pkg::node_t'(rdata);

  cppi_ram #(
    .WIDTH (cppi_pkg::NODE_WORD_W),
    .DEPTH (cppi_pkg::MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.node_index),
    .wdata (wr_node),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Shift-add multiplier step
  logic [cppi_pkg::ACC_W-1:0] madd;
  logic [cppi_pkg::ACC_W-1:0] acc_next;
  always_comb begin
    madd     = opb[0] ? (mneg ? -opa : opa) : '0;
    acc_next = acc + madd;
  end

  // Restoring divider step
  logic [cppi_pkg::REM_W-1:0] rem_sh;
  logic                       dge;
  logic [cppi_pkg::REM_W-1:0] rem_dn;
  logic [cppi_pkg::DV_W-1:0]  dv_dn;
  always_comb begin
    rem_sh = {rem[cppi_pkg::REM_W-2:0], dv[cppi_pkg::DV_W-1]};
    dge    = rem_sh >= {1'b0, den};
    rem_dn = dge ? rem_sh - {1'b0, den} : rem_sh;
    dv_dn  = {dv[cppi_pkg::DV_W-2:0], dge};
  end

  // Square root step, two radicand bits at a time
  logic [cppi_pkg::REM_W-1:0]  rsh;
  logic [cppi_pkg::REM_W-1:0]  trial;
  logic                        sge;
  logic [cppi_pkg::REM_W-1:0]  rem_sq;
  logic [cppi_pkg::ROOT_W-1:0] root_next;
  always_comb begin
    rsh       = {rem[cppi_pkg::REM_W-3:0], dv[cppi_pkg::DV_W-1 -: 2]};
    trial     = {3'b000, root, 2'b01};
    sge       = rsh >= trial;
    rem_sq    = sge ? rsh - trial : rsh;
    root_next = {root[cppi_pkg::ROOT_W-2:0], sge};
  end

  // Operand preparation
  logic signed [cppi_pkg::MAG_W-1:0]   dx;
  logic signed [cppi_pkg::MAG_W-1:0]   dy;
  logic signed [cppi_pkg::COORD_W-1:0] lb;
  logic [cppi_pkg::ACC_W-1:0]          num_mag;
  logic [cppi_pkg::MAG_W-1:0]          qmag;
  logic [cppi_pkg::MAG_W-1:0]          qres;
  logic [cppi_pkg::MS_W-1:0]           t_less_e;
  always_comb begin
    dx       = {rd_node.x[cppi_pkg::COORD_W-1], rd_node.x}
             - {seg_sx[cppi_pkg::COORD_W-1], seg_sx};
    dy       = {ny[cppi_pkg::COORD_W-1], ny} - {seg_sy[cppi_pkg::COORD_W-1], seg_sy};
    lb       = axis ? ny : nx;
    num_mag  = acc_next[cppi_pkg::ACC_W-1] ? -acc_next : acc_next;
    qmag     = dv_dn[cppi_pkg::MAG_W-1:0];
    qres     = qneg ? -qmag : qmag;
    t_less_e = ms - elapsed[cppi_pkg::MS_W-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      node_count <= cppi_pkg::COUNT_W'(1);
      cur_node   <= '0;
      nxt_node   <= '0;
      seg_start  <= '0;
      seg_sx     <= '0;
      seg_sy     <= '0;
      cur_x      <= '0;
      cur_y      <= '0;
      started    <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      // Drop the result once taken, unless a new one is loaded this cycle
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_data.operation)
              cppi_pkg::OP_TICK: begin
                if (!started) begin
                  started   <= 1'b1;
                  seg_start <= in_data.tick_ms;
                  state     <= S_OUT;
                end else begin
                  elapsed  <= in_data.tick_ms - seg_start;
                  lap      <= '0;
                  n        <= '0;
                  lap_done <= 1'b0;
                  stepping <= 1'b0;
                  state    <= S_RD_CUR;
                end
              end
              cppi_pkg::OP_WRITE: begin
                state <= S_OUT;
              end
              cppi_pkg::OP_RESTART: begin
                cur_node <= '0;
                nxt_node <= succ('0, count_eff);
                started  <= 1'b0;
                state    <= S_RS_RD;
              end
              cppi_pkg::OP_SETPOS: begin
                seg_sx  <= in_data.node_x;
                seg_sy  <= in_data.node_y;
                cur_x   <= in_data.node_x;
                cur_y   <= in_data.node_y;
                started <= 1'b0;
                state   <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end

        S_RS_RD: begin
          state <= S_RS_LD;
        end

        S_RS_LD: begin
          seg_sx <= rd_node.x;
          seg_sy <= rd_node.y;
          cur_x  <= rd_node.x;
          cur_y  <= rd_node.y;
          state  <= S_OUT;
        end

        // Fetch the segment start node, then the target node
        S_RD_CUR: begin
          state <= S_RD_NXT;
        end

        S_RD_NXT: begin
          spd <= rd_node.speed;
          if (stepping) begin
            seg_sx <= rd_node.x;
            seg_sy <= rd_node.y;
          end
          state <= S_LD_NXT;
        end

        S_LD_NXT: begin
          nx    <= rd_node.x;
          ny    <= rd_node.y;
          acc   <= '0;
          mneg  <= 1'b0;
          opa   <= cppi_pkg::ACC_W'(mag17(dx));
          opb   <= cppi_pkg::OPB_W'(mag17(dx));
          cnt   <= cppi_pkg::CNT_W'(cppi_pkg::SQ_STEPS);
          state <= S_MDX;
        end

        // Squared distance, then scale by one million
        S_MDX: begin
          acc <= acc_next;
          if (last) begin
            opa   <= cppi_pkg::ACC_W'(mag17(dy));
            opb   <= cppi_pkg::OPB_W'(mag17(dy));
            cnt   <= cppi_pkg::CNT_W'(cppi_pkg::SQ_STEPS);
            state <= S_MDY;
          end else begin
            opa <= opa << 1;
            opb <= opb >> 1;
            cnt <= cnt - cppi_pkg::CNT_W'(1);
          end
        end

        S_MDY: begin
          if (last) begin
            acc   <= '0;
            opa   <= acc_next;
            opb   <= cppi_pkg::SCALE;
            cnt   <= cppi_pkg::CNT_W'(cppi_pkg::SCALE_BITS);
            state <= S_MK;
          end else begin
            acc <= acc_next;
            opa <= opa << 1;
            opb <= opb >> 1;
            cnt <= cnt - cppi_pkg::CNT_W'(1);
          end
        end

        S_MK: begin
          acc <= acc_next;
          if (last) begin
            dv    <= acc_next;
            rem   <= '0;
            root  <= '0;
            cnt   <= cppi_pkg::CNT_W'(cppi_pkg::SQRT_STEPS);
            state <= S_SQRT;
          end else begin
            opa <= opa << 1;
            opb <= opb >> 1;
            cnt <= cnt - cppi_pkg::CNT_W'(1);
          end
        end

        S_SQRT: begin
          root <= root_next;
          if (last) begin
            if (spd == '0) begin
              ms    <= '0;
              state <= S_CHK;
            end else begin
              dv    <= {root_next, {(cppi_pkg::DV_W - cppi_pkg::SEG_K){1'b0}}};
              rem   <= '0;
              den   <= cppi_pkg::TIME_W'(spd);
              cnt   <= cppi_pkg::CNT_W'(cppi_pkg::SEG_K);
              state <= S_DIVT;
            end
          end else begin
            rem <= rem_sq;
            dv  <= {dv[cppi_pkg::DV_W-3:0], 2'b00};
            cnt <= cnt - cppi_pkg::CNT_W'(1);
          end
        end

        S_DIVT: begin
          rem <= rem_dn;
          dv  <= dv_dn;
          if (last) begin
            ms    <= dv_dn[cppi_pkg::MS_W-1:0];
            state <= S_CHK;
          end else begin
            cnt <= cnt - cppi_pkg::CNT_W'(1);
          end
        end

        // Stop on a zero-time segment, skip whole laps once a lap is known
        S_CHK: begin
          if (stepping && ms == '0) begin
            cur_x <= seg_sx;
            cur_y <= seg_sy;
            state <= S_OUT;
          end else if (stepping && !lap_done && n == count_eff + cppi_pkg::COUNT_W'(2)) begin
            lap_done <= 1'b1;
            if (lap != '0) begin
              dv    <= {elapsed, {(cppi_pkg::DV_W - cppi_pkg::MOD_K){1'b0}}};
              rem   <= '0;
              den   <= lap;
              cnt   <= cppi_pkg::CNT_W'(cppi_pkg::MOD_K);
              state <= S_MOD;
            end else begin
              state <= S_TEST;
            end
          end else begin
            state <= S_TEST;
          end
        end

        S_MOD: begin
          rem <= rem_dn;
          dv  <= dv_dn;
          cnt <= cnt - cppi_pkg::CNT_W'(1);
          if (last) begin
            state <= S_MODF;
          end
        end

        S_MODF: begin
          seg_start <= seg_start + (elapsed - rem[cppi_pkg::TIME_W-1:0]);
          elapsed   <= rem[cppi_pkg::TIME_W-1:0];
          state     <= S_TEST;
        end

        // Advance over an elapsed segment, or start interpolating
        S_TEST: begin
          if (elapsed >= cppi_pkg::TIME_W'(ms)) begin
            elapsed   <= elapsed - cppi_pkg::TIME_W'(ms);
            seg_start <= seg_start + cppi_pkg::TIME_W'(ms);
            if (!lap_done) begin
              n <= n + cppi_pkg::COUNT_W'(1);
              if (n >= cppi_pkg::COUNT_W'(2)) begin
                lap <= lap + cppi_pkg::TIME_W'(ms);
              end
            end
            cur_node <= nxt_node;
            nxt_node <= succ(nxt_node, count_eff);
            stepping <= 1'b1;
            state    <= S_RD_CUR;
          end else begin
            axis  <= 1'b0;
            acc   <= '0;
            opa   <= cppi_pkg::ACC_W'(t_less_e);
            opb   <= cppi_pkg::OPB_W'(mag17({seg_sx[cppi_pkg::COORD_W-1], seg_sx}));
            mneg  <= seg_sx[cppi_pkg::COORD_W-1];
            cnt   <= cppi_pkg::CNT_W'(cppi_pkg::SQ_STEPS);
            state <= S_LA;
          end
        end

        // Interpolate: a * (t - e) + b * e, then divide by t
        S_LA: begin
          acc <= acc_next;
          if (last) begin
            opa   <= cppi_pkg::ACC_W'(elapsed[cppi_pkg::MS_W-1:0]);
            opb   <= cppi_pkg::OPB_W'(mag17({lb[cppi_pkg::COORD_W-1], lb}));
            mneg  <= lb[cppi_pkg::COORD_W-1];
            cnt   <= cppi_pkg::CNT_W'(cppi_pkg::SQ_STEPS);
            state <= S_LB;
          end else begin
            opa <= opa << 1;
            opb <= opb >> 1;
            cnt <= cnt - cppi_pkg::CNT_W'(1);
          end
        end

        S_LB: begin
          acc <= acc_next;
          if (last) begin
            qneg  <= acc_next[cppi_pkg::ACC_W-1];
            dv    <= {num_mag[cppi_pkg::LERP_K-1:0], {(cppi_pkg::DV_W - cppi_pkg::LERP_K){1'b0}}};
            rem   <= '0;
            den   <= cppi_pkg::TIME_W'(ms);
            cnt   <= cppi_pkg::CNT_W'(cppi_pkg::LERP_K);
            state <= S_LDIV;
          end else begin
            opa <= opa << 1;
            opb <= opb >> 1;
            cnt <= cnt - cppi_pkg::CNT_W'(1);
          end
        end

        S_LDIV: begin
          rem <= rem_dn;
          dv  <= dv_dn;
          if (last) begin
            if (!axis) begin
              cur_x <= qres[cppi_pkg::COORD_W-1:0];
              axis  <= 1'b1;
              acc   <= '0;
              opa   <= cppi_pkg::ACC_W'(t_less_e);
              opb   <= cppi_pkg::OPB_W'(mag17({seg_sy[cppi_pkg::COORD_W-1], seg_sy}));
              mneg  <= seg_sy[cppi_pkg::COORD_W-1];
              cnt   <= cppi_pkg::CNT_W'(cppi_pkg::SQ_STEPS);
              state <= S_LA;
            end else begin
              cur_y <= qres[cppi_pkg::COORD_W-1:0];
              state <= S_OUT;
            end
          end else begin
            cnt <= cnt - cppi_pkg::CNT_W'(1);
          end
        end

        // Hold the result until the output register is free
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= '{pos_x: cur_x, pos_y: cur_y, segment_node: cur_node,
                           timing_started: started};
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.operation == cppi_pkg::OP_TICK) |=> started)
    else $error("tick left timing unstarted");

  a_setpos: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.operation == cppi_pkg::OP_SETPOS) |=>
      (!started && cur_x == $past(in_data.node_x) && cur_y == $past(in_data.node_y)))
    else $error("set position not applied");

  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK && spd == '0) |-> (ms == '0))
    else $error("zero speed gave a nonzero segment time");

  a_lerp_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LA) |-> (ms != '0 && cppi_pkg::TIME_W'(ms) > elapsed))
    else $error("interpolation outside the current segment");
`endif

endmodule

>>> design/cppi_ram.sv
module cppi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
